/* rtl/sacn_pkg.sv */
package sacn_pkg;

  localparam int unsigned ADDR_BITS_DEF = 32;
  localparam int unsigned SETS_DEF      = 256;
  localparam int unsigned WAYS_DEF      = 8;

  // configuration register widths
  localparam int unsigned OFF_REG_W  = 5;
  localparam int unsigned IDX_REG_W  = 4;
  localparam int unsigned WAYS_REG_W = 4;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned CFG_IDX_W  = 2;

  // widest set index the index register can ask for
  localparam int unsigned SET_IDX_MAX_W = (1 << IDX_REG_W) - 1;

  // result field widths
  localparam int unsigned WAY_OUT_W = 3;
  localparam int unsigned MISS_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 2'd0,
    CFG_INDEX_BITS  = 2'd1,
    CFG_WAYS_IN_USE = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_LOOK
  } state_e;

endpackage

/* rtl/sacn_if.sv */
interface sacn_in_if #(
  parameter int unsigned ADDR_BITS = sacn_pkg::ADDR_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] lookup_addr;

  modport source (output valid, output lookup_addr, input ready);
  modport sink   (input valid, input lookup_addr, output ready);
endinterface

interface sacn_out_if ();
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [sacn_pkg::WAY_OUT_W-1:0]  way_used;
  logic [sacn_pkg::MISS_W-1:0]     miss_total;

  modport source (output valid, output hit, output way_used, output miss_total,
                  input ready);
  modport sink   (input valid, input hit, input way_used, input miss_total,
                  output ready);
endinterface

/* rtl/sacn_ram.sv */
module sacn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sacn_addr_split.sv */
module sacn_addr_split #(
  parameter int unsigned ADDR_BITS = sacn_pkg::ADDR_BITS_DEF,
  parameter int unsigned SETS      = sacn_pkg::SETS_DEF
) (
  input  logic [ADDR_BITS-1:0]                    addr_i,
  input  logic [sacn_pkg::OFF_REG_W-1:0]          offset_bits_i,
  input  logic [sacn_pkg::IDX_REG_W-1:0]          index_bits_i,
  output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] set_o,
  output logic [ADDR_BITS-1:0]                    tag_o
);
  import sacn_pkg::*;

  localparam int unsigned SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned IDX_W = SET_IDX_MAX_W;
  localparam int unsigned XW    = (ADDR_BITS > IDX_W) ? ADDR_BITS : IDX_W;

  logic [ADDR_BITS-1:0] block;
  logic [XW-1:0]        block_x;
  logic [IDX_W-1:0]     idx;

  assign block   = addr_i >> offset_bits_i;
  assign block_x = XW'(block);
  assign idx     = block_x[IDX_W-1:0] & ~({IDX_W{1'b1}} << index_bits_i);
  assign tag_o   = block >> index_bits_i;

  if ((SETS & (SETS - 1)) == 0) begin : g_pow2
    assign set_o = (SETS == 1) ? '0 : SW'(idx);
  end else begin : g_reduce
    localparam int unsigned C  = $clog2(SETS);
    localparam int unsigned NK = (C >= IDX_W) ? 1 : IDX_W - C + 1;
    logic [IDX_W-1:0] red;

    // restoring reduction against shifted copies of the set count
    always_comb begin
      red = idx;
      for (int k = NK - 1; k >= 0; k--) begin
        if (32'(red) >= (32'(SETS) << k)) begin
          red = red - IDX_W'(32'(SETS) << k);
        end
      end
    end

    assign set_o = SW'(red);
  end

endmodule

/* rtl/sacn_way_sel.sv */
module sacn_way_sel #(
  parameter int unsigned ADDR_BITS = sacn_pkg::ADDR_BITS_DEF,
  parameter int unsigned WAYS      = sacn_pkg::WAYS_DEF
) (
  input  logic [WAYS-1:0][ADDR_BITS-1:0]          tags_i,
  input  logic [WAYS-1:0]                         valid_i,
  input  logic [WAYS-1:0]                         nru_i,
  input  logic [ADDR_BITS-1:0]                    tag_i,
  input  logic [$clog2(WAYS+1)-1:0]               nways_i,
  output logic                                    hit_o,
  output logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] way_o,
  output logic [WAYS-1:0][ADDR_BITS-1:0]          tags_o,
  output logic [WAYS-1:0]                         valid_o,
  output logic [WAYS-1:0]                         nru_o
);

  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic [WAYS-1:0] en;
  logic [WAYS-1:0] match;
  logic [WAYS-1:0] empty;
  logic [WAYS-1:0] stale;
  logic [WAYS-1:0] way_bit;
  logic [WAYS-1:0] nru_base;
  logic            all_recent;

  function automatic logic [WW-1:0] first_one(input logic [WAYS-1:0] v);
    logic [WW-1:0] r;
    r = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WW'(i);
      end
    end
    return r;
  endfunction

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      en[w]    = (w < int'(nways_i));
      match[w] = en[w] && valid_i[w] && (tags_i[w] == tag_i);
      empty[w] = en[w] && !valid_i[w];
      stale[w] = en[w] && nru_i[w];
    end
  end

  assign hit_o      = |match;
  assign all_recent = !hit_o && !(|empty) && !(|stale);

  always_comb begin
    priority if (hit_o) begin
      way_o = first_one(match);
    end else if (|empty) begin
      way_o = first_one(empty);
    end else if (|stale) begin
      way_o = first_one(stale);
    end else begin
      way_o = '0;
    end
  end

  assign way_bit  = WAYS'(1) << way_o;
  // every way in use recently touched: age them all before taking way 0
  assign nru_base = all_recent ? (nru_i | en) : nru_i;
  assign nru_o    = nru_base & ~way_bit;
  assign valid_o  = hit_o ? valid_i : (valid_i | way_bit);

  always_comb begin
    tags_o = tags_i;
    if (!hit_o) begin
      tags_o[way_o] = tag_i;
    end
  end

endmodule

/* rtl/set_assoc_cache_nru_lookup_top.sv */
// Channel   Dir  Handshake      Payload
// in_if     in   valid/ready    lookup_addr
// out_if    out  valid/ready    hit, way_used, miss_total
// cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (offset, index, ways)
//
// Each item passes through ST_PREP, which splits the address and reads the set's row,
// and ST_LOOK, which picks the way and writes the row back through the RAM write port.
// A new item can be taken in the write-back cycle of the one before it.
// After reset a clearing pass over all SETS rows empties every set; no item is
// taken meanwhile. A stalled output holds the write-back until it drains.
module set_assoc_cache_nru_lookup_top #(
  parameter int unsigned ADDR_BITS = sacn_pkg::ADDR_BITS_DEF,
  parameter int unsigned SETS      = sacn_pkg::SETS_DEF,
  parameter int unsigned WAYS      = sacn_pkg::WAYS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  sacn_in_if.sink                         in_if,
  sacn_out_if.source                      out_if,
  input  logic                            cfg_we_i,
  input  logic [sacn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sacn_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sacn_pkg::*;

  localparam int unsigned SW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned NW_W = $clog2(WAYS + 1);
  localparam int unsigned RW   = WAYS * (ADDR_BITS + 2);

  state_e state_q, state_d;

  logic [OFF_REG_W-1:0]  off_q;
  logic [IDX_REG_W-1:0]  idxb_q;
  logic [NW_W-1:0]       nways_q;
  logic [WAYS_REG_W-1:0] ways_val;
  logic [NW_W-1:0]       nways_wr;

  logic [SW-1:0]        clr_cnt_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [SW-1:0]        set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic [MISS_W-1:0]    miss_q, miss_d;

  logic                 out_valid_q;
  logic                 out_hit_q;
  logic [WAY_OUT_W-1:0] out_way_q;
  logic [MISS_W-1:0]    out_miss_q;

  logic                 in_acc;
  logic                 lk_done;
  logic                 ram_re, ram_we;
  logic [SW-1:0]        ram_waddr;
  logic [RW-1:0]        ram_wdata, ram_rdata;

  logic [SW-1:0]        sp_set;
  logic [ADDR_BITS-1:0] sp_tag;

  logic [WAYS-1:0][ADDR_BITS-1:0] rd_tags, wr_tags;
  logic [WAYS-1:0]                rd_valid, wr_valid, rd_nru, wr_nru;
  logic                           lk_hit;
  logic [WW-1:0]                  lk_way;

  // configuration
  assign ways_val = cfg_data_i[WAYS_REG_W-1:0];
  assign nways_wr = (ways_val == '0) ? NW_W'(1) :
                    (int'(ways_val) > int'(WAYS)) ? NW_W'(WAYS) : NW_W'(ways_val);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= '0;
      idxb_q  <= '0;
      nways_q <= NW_W'(WAYS);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_OFFSET_BITS: off_q   <= cfg_data_i[OFF_REG_W-1:0];
        CFG_INDEX_BITS:  idxb_q  <= cfg_data_i[IDX_REG_W-1:0];
        CFG_WAYS_IN_USE: nways_q <= nways_wr;
        default: ;
      endcase
    end
  end

  // control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == SW'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: state_d = ST_LOOK;
      ST_LOOK: begin
        if (lk_done) begin
          state_d = in_acc ? ST_PREP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    lk_done   = (state_q == ST_LOOK) && (!out_valid_q || out_if.ready);
    ram_re    = (state_q == ST_PREP);
    ram_we    = (state_q == ST_CLEAR) || lk_done;
    ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : set_q;
    ram_wdata = (state_q == ST_CLEAR) ? {{(WAYS * ADDR_BITS){1'b0}}, {WAYS{1'b1}},
                                         {WAYS{1'b0}}}
                                      : {wr_tags, wr_nru, wr_valid};
    in_if.ready = (state_q == ST_IDLE) || lk_done;
  end

  assign in_acc = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      miss_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + SW'(1);
      end
      if (lk_done) begin
        miss_q <= miss_d;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q <= in_if.lookup_addr;
    end
    if (state_q == ST_PREP) begin
      set_q <= sp_set;
      tag_q <= sp_tag;
    end
  end

  sacn_addr_split #(
    .ADDR_BITS (ADDR_BITS),
    .SETS      (SETS)
  ) u_split (
    .addr_i        (addr_q),
    .offset_bits_i (off_q),
    .index_bits_i  (idxb_q),
    .set_o         (sp_set),
    .tag_o         (sp_tag)
  );

  sacn_ram #(
    .WIDTH (RW),
    .DEPTH (SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (sp_set),
    .rdata_o (ram_rdata)
  );

  assign {rd_tags, rd_nru, rd_valid} = ram_rdata;

  sacn_way_sel #(
    .ADDR_BITS (ADDR_BITS),
    .WAYS      (WAYS)
  ) u_sel (
    .tags_i  (rd_tags),
    .valid_i (rd_valid),
    .nru_i   (rd_nru),
    .tag_i   (tag_q),
    .nways_i (nways_q),
    .hit_o   (lk_hit),
    .way_o   (lk_way),
    .tags_o  (wr_tags),
    .valid_o (wr_valid),
    .nru_o   (wr_nru)
  );

  assign miss_d = lk_hit ? miss_q : miss_q + MISS_W'(1);

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (lk_done) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lk_done) begin
      out_hit_q  <= lk_hit;
      out_way_q  <= WAY_OUT_W'(lk_way);
      out_miss_q <= miss_d;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.hit        = out_hit_q;
  assign out_if.way_used   = out_way_q;
  assign out_if.miss_total = out_miss_q;

`ifndef SYNTHESIS
  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_re && ram_we))
    else $error("row read and write-back in the same cycle");

  a_miss_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lk_done && !lk_hit) |=> (miss_q == $past(miss_q) + MISS_W'(1)))
    else $error("miss count did not advance on a miss");

  a_hit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lk_done && lk_hit) |=> $stable(miss_q))
    else $error("miss count changed on a hit");

  a_way_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lk_done |-> (int'(lk_way) < int'(nways_q)))
    else $error("selected way lies outside the ways in use");
`endif

endmodule
